// ===== rtl/core/gal_pkg.sv =====
// ----------------------------------------------------------------------------
// gal_pkg: shared definitions for the glyph address lookup
// Opcodes, register indexes, table sizes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gal_pkg;

  // Transaction opcodes
  localparam logic [1:0] OP_LOOKUP    = 2'd0;
  localparam logic [1:0] OP_WR_CODE   = 2'd1;
  localparam logic [1:0] OP_WR_OFFSET = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_MIN_FIRST  = 2'd0;
  localparam logic [1:0] REG_MAX_FIRST  = 2'd1;
  localparam logic [1:0] REG_MIN_SECOND = 2'd2;
  localparam logic [1:0] REG_MAX_SECOND = 2'd3;

  localparam logic [7:0] MAX_SECOND_RESET = 8'hFF;

  // Code table entry marking an absent character
  localparam logic [15:0] ABSENT_CODE = 16'hFFFF;

  // Default table depths
  localparam int CODE_SLOTS_DEF  = 65536;
  localparam int GLYPH_SLOTS_DEF = 4096;

endpackage

`default_nettype wire

// ===== rtl/core/glyph_address_lookup_core.sv =====
// ----------------------------------------------------------------------------
// glyph_address_lookup_core
// Maps a one- or two-byte character code to a glyph number through the code
// table memory, then to a bitmap byte offset through the offset memory.
// ----------------------------------------------------------------------------
// Result: a lookup shows on out_valid once its transaction has passed the input
//   register, the row product register, the code memory read and the offset memory read.
// Throughput: one transaction per cycle while the output is not stalled; the
//   pipeline holds as a whole while a result waits on out_stall.
// Reset: rst clears the pipeline valid bits and returns the bound registers
//   to one row of 256 columns; the two table memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module glyph_address_lookup_core #(
  parameter int CODE_SLOTS  = gal_pkg::CODE_SLOTS_DEF,
  parameter int GLYPH_SLOTS = gal_pkg::GLYPH_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  first_byte,
  input  wire logic [7:0]  second_byte,
  input  wire logic        two_byte,
  input  wire logic [15:0] table_addr,
  input  wire logic [30:0] table_data,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             found,
  output logic [15:0]      glyph_number,
  output logic [30:0]      bitmap_offset
);

  import gal_pkg::*;

  localparam int CIDX_W = (CODE_SLOTS > 1) ? $clog2(CODE_SLOTS) : 1;
  localparam int GIDX_W = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;

  // --------------------------------------------------------------------------
  // Configuration: encoding bounds, and the table shape derived from them.
  // Shape registers are loaded from the bound registers and follow a change in the next cycle.
  // --------------------------------------------------------------------------
  logic [7:0]  min_first;
  logic [7:0]  max_first;
  logic [7:0]  min_second;
  logic [7:0]  max_second;

  logic signed [9:0] cols_next;
  logic signed [9:0] rows_next;
  logic signed [9:0] cols;
  logic [16:0]       size;
  logic              shape_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_first  <= '0;
      max_first  <= '0;
      min_second <= '0;
      max_second <= MAX_SECOND_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MIN_FIRST:  min_first  <= cfg_data;
        REG_MAX_FIRST:  max_first  <= cfg_data;
        REG_MIN_SECOND: min_second <= cfg_data;
        REG_MAX_SECOND: max_second <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cols_next = $signed({2'b00, max_second}) - $signed({2'b00, min_second}) + 10'sd1;
  assign rows_next = $signed({2'b00, max_first}) - $signed({2'b00, min_first}) + 10'sd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_ok <= 1'b0;
    end else begin
      shape_ok <= (cols_next > 10'sd0) && (rows_next > 10'sd0);
    end
    cols <= cols_next;
    size <= {8'b0, cols_next[8:0]} * {8'b0, rows_next[8:0]};
  end

  // --------------------------------------------------------------------------
  // Pipeline control: every stage advances together unless a result waits.
  // --------------------------------------------------------------------------
  logic adv;
  logic in_accept;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign in_accept = in_valid && adv;

  // --------------------------------------------------------------------------
  // Stage A: registered transaction; form the signed byte differences.
  // --------------------------------------------------------------------------
  logic        a_valid;
  logic [1:0]  a_op;
  logic [7:0]  a_first;
  logic [7:0]  a_second;
  logic        a_two;
  logic [15:0] a_addr;
  logic [30:0] a_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_accept;
    end
    if (adv) begin
      a_op     <= opcode;
      a_first  <= first_byte;
      a_second <= second_byte;
      a_two    <= two_byte;
      a_addr   <= table_addr;
      a_data   <= table_data;
    end
  end

  logic signed [8:0]  d_first;
  logic signed [8:0]  d_second;
  logic signed [8:0]  d_single;
  logic signed [18:0] prod_next;

  assign d_first   = $signed({1'b0, a_first}) - $signed({1'b0, min_first});
  assign d_second  = $signed({1'b0, a_second}) - $signed({1'b0, min_second});
  assign d_single  = $signed({1'b0, a_first}) - $signed({1'b0, min_second});
  assign prod_next = 19'(d_first) * 19'(cols);

  // --------------------------------------------------------------------------
  // Stage B: row product registered; finish the index, access the code table.
  // --------------------------------------------------------------------------
  logic               b_valid;
  logic [1:0]         b_op;
  logic               b_two;
  logic signed [18:0] b_prod;
  logic signed [8:0]  b_d_second;
  logic signed [8:0]  b_d_single;
  logic [15:0]        b_addr;
  logic [30:0]        b_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
    if (adv) begin
      b_op       <= a_op;
      b_two      <= a_two;
      b_prod     <= prod_next;
      b_d_second <= d_second;
      b_d_single <= d_single;
      b_addr     <= a_addr;
      b_data     <= a_data;
    end
  end

  logic signed [19:0] idx;
  logic               idx_ok;
  logic               code_wr;

  assign idx = b_two ? (20'(b_prod) + 20'(b_d_second)) : 20'(b_d_single);
  assign idx_ok = shape_ok && !idx[19]
                  && ($unsigned(idx) < 20'(size))
                  && ($unsigned(idx) < 20'(CODE_SLOTS));
  assign code_wr = b_valid && (b_op == OP_WR_CODE)
                   && ({1'b0, b_addr} < 17'(CODE_SLOTS));

  logic [15:0] code_mem [CODE_SLOTS];
  logic [15:0] code_q;

  // Writes and lookups meet this port in order; the read runs beside any write.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (code_wr) begin
        code_mem[b_addr[CIDX_W-1:0]] <= b_data[15:0];
      end
      code_q <= code_mem[idx[CIDX_W-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: code entry read; qualify the glyph, access the offset table.
  // --------------------------------------------------------------------------
  logic        c_valid;
  logic [1:0]  c_op;
  logic        c_idx_ok;
  logic [15:0] c_addr;
  logic [30:0] c_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
    if (adv) begin
      c_op     <= b_op;
      c_idx_ok <= idx_ok;
      c_addr   <= b_addr;
      c_data   <= b_data;
    end
  end

  logic glyph_ok;
  logic off_wr;

  assign glyph_ok = c_idx_ok && (code_q != ABSENT_CODE)
                    && ({1'b0, code_q} < 17'(GLYPH_SLOTS));
  assign off_wr   = c_valid && (c_op == OP_WR_OFFSET)
                    && ({1'b0, c_addr} < 17'(GLYPH_SLOTS));

  logic [30:0] off_mem [GLYPH_SLOTS];
  logic [30:0] off_q;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (off_wr) begin
        off_mem[c_addr[GIDX_W-1:0]] <= c_data;
      end
      off_q <= off_mem[code_q[GIDX_W-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: output register; only lookups produce a result transaction.
  // --------------------------------------------------------------------------
  logic        found_r;
  logic [15:0] glyph_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= c_valid && (c_op == OP_LOOKUP);
    end
    if (adv) begin
      found_r <= glyph_ok;
      glyph_q <= code_q;
    end
  end

  // Drop the table contents when nothing was found.
  assign found         = found_r;
  assign glyph_number  = found_r ? glyph_q : '0;
  assign bitmap_offset = found_r ? off_q : '0;

`ifndef SYNTHESIS
  a_found_not_absent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (glyph_number != ABSENT_CODE))
    else $error("found result carries the absent code");

  a_found_in_store: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> ({1'b0, glyph_number} < 17'(GLYPH_SLOTS)))
    else $error("found glyph lies beyond the offset store");

  a_result_from_lookup: assert property (@(posedge clk) disable iff (rst)
    (adv && c_valid && (c_op == OP_LOOKUP)) |=> out_valid)
    else $error("lookup in flight produced no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    (adv && !(c_valid && (c_op == OP_LOOKUP))) |=> !out_valid)
    else $error("result without a lookup");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (a_valid == $past(a_valid)) && (code_q === $past(code_q)))
    else $error("pipeline moved while the output was stalled");
`endif

endmodule

`default_nettype wire
